### src/sonar_gnss_nearest_fix_batcher_core_macros.svh
// assertion macros for the sonar / gnss nearest-fix batcher
// used by the top level; expects clk and rst_n in the including scope
`ifndef SONAR_GNSS_NEAREST_FIX_BATCHER_CORE_MACROS_SVH
`define SONAR_GNSS_NEAREST_FIX_BATCHER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SNGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SNGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sngb_pkg.sv
// shared constants, codes and payload types of the nearest-fix batcher
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sngb_pkg;

    localparam int SLOT_COUNT     = 32;
    localparam int STAMP_BITS     = 48;
    localparam int TAG_BITS       = 16;
    localparam int SOS_BITS       = 32;
    localparam int CMD_BITS       = 2;
    localparam int STATE_BITS     = 2;
    localparam int INDEX_OUT_BITS = 5;
    localparam int SLOT_IDX_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_BITS     = $clog2(SLOT_COUNT + 1);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_START = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SOS   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FIX   = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_SONAR = 2'd3;

    // batch state codes
    typedef enum logic [STATE_BITS-1:0] {
        BS_SOS_MISSING  = 2'd0,
        BS_GNSS_MISSING = 2'd1,
        BS_COMPLETE     = 2'd2
    } batch_state_t;

    // input item
    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [STAMP_BITS-1:0] stamp;
        logic [TAG_BITS-1:0]   tag;
        logic [SOS_BITS-1:0]   sos_value;
    } item_t;

    // result item
    typedef struct packed {
        logic [STATE_BITS-1:0]     batch_state;
        logic                      slot_valid;
        logic [INDEX_OUT_BITS-1:0] slot_index;
        logic [TAG_BITS-1:0]       sonar_tag;
        logic [TAG_BITS-1:0]       fix_tag;
        logic [STAMP_BITS-1:0]     fix_stamp;
        logic                      slot_dropped;
        logic [SOS_BITS-1:0]       sos_first;
        logic [SOS_BITS-1:0]       sos_second;
        logic                      last;
    } result_t;

    // decoded command, one flag per kind
    typedef struct packed {
        logic is_start;
        logic is_sos;
        logic is_fix;
        logic is_sonar;
    } op_t;

    // queue entry between front and back
    typedef struct packed {
        op_t                   op;
        logic [STAMP_BITS-1:0] stamp;
        logic [TAG_BITS-1:0]   tag;
        logic [SOS_BITS-1:0]   sos_value;
    } entry_t;

    // one slot of the store
    typedef struct packed {
        logic [STAMP_BITS-1:0] sonar_stamp;
        logic [TAG_BITS-1:0]   sonar_tag;
        logic [STAMP_BITS-1:0] fix_stamp;
        logic [TAG_BITS-1:0]   fix_tag;
    } slot_t;

    // slot store write request
    typedef struct packed {
        logic                     sonar_en;
        logic                     fix_en;
        logic [SLOT_IDX_BITS-1:0] addr;
        slot_t                    data;
    } slot_wr_t;

    // slot store read request
    typedef struct packed {
        logic                     en;
        logic [SLOT_IDX_BITS-1:0] addr;
    } slot_rd_t;

endpackage

### src/sonar_gnss_nearest_fix_batcher_core.sv
// top level of the sonar / gnss nearest-fix batcher
// depends on sngb_pkg, sngb_front, sngb_back and the assertion macro header
//
// channel   signals                              direction
// -------   ----------------------------------   ---------
// item      item_valid, item_ready, item          in
// result    result_valid, result_ready, result    out
//
// a command that completes no slot yields one status result in the cycle after it
// leaves the two-entry queue; a gnss fix walks its pending slots, one slot per cycle
// while the result is not stalled, paced by the single read port of the slot store
// the queue takes up to two items while the back end walks slots or the result waits
// a stalled result pauses the walk; no clearing pass after reset
`timescale 1ns / 1ps
`include "sonar_gnss_nearest_fix_batcher_core_macros.svh"

module sonar_gnss_nearest_fix_batcher_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sngb_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output sngb_pkg::result_t result
);
    import sngb_pkg::*;

    entry_t q_entry;
    logic   q_valid;
    logic   q_ready;

    // decode and queue
    sngb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .q_entry    (q_entry),
        .q_valid    (q_valid),
        .q_ready    (q_ready)
    );

    // execution and result register
    sngb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_entry      (q_entry),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // checks
    `SNGB_ASSERT_NOW(a_status_is_last, result_valid && !result.slot_valid, result.last, "status result without last")
    `SNGB_ASSERT_NOW(a_drop_only_open, result_valid && result.slot_dropped, !result.slot_valid && (result.batch_state == BS_SOS_MISSING), "drop flag outside open batch")
    `SNGB_ASSERT_NOW(a_complete_on_last, result_valid && result.slot_valid && (result.batch_state == BS_COMPLETE), result.last, "batch completed before final slot")
    `SNGB_ASSERT_NEXT(a_queue_holds, q_valid && !q_ready, q_valid, "queue entry lost without transfer")

endmodule

### src/sngb_slot_store.sv
// slot store: sonar half and fix half memories, one write and one read port
// depends on sngb_pkg
`timescale 1ns / 1ps

module sngb_slot_store (
    input  logic             clk,
    input  sngb_pkg::slot_wr_t wr,
    input  sngb_pkg::slot_rd_t rd,
    output sngb_pkg::slot_t    rd_data
);
    import sngb_pkg::*;

    localparam int HALF_BITS = STAMP_BITS + TAG_BITS;

    logic [HALF_BITS-1:0] sonar_mem [SLOT_COUNT];
    logic [HALF_BITS-1:0] fix_mem   [SLOT_COUNT];
    logic [HALF_BITS-1:0] sonar_q_reg;
    logic [HALF_BITS-1:0] fix_q_reg;

    // writes: sonar half only on a new sample, fix half on sample or update
    always_ff @(posedge clk)
    begin
        if (wr.sonar_en)
        begin
            sonar_mem[wr.addr] <= {wr.data.sonar_stamp, wr.data.sonar_tag};
        end
        if (wr.fix_en)
        begin
            fix_mem[wr.addr] <= {wr.data.fix_stamp, wr.data.fix_tag};
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            sonar_q_reg <= sonar_mem[rd.addr];
            fix_q_reg   <= fix_mem[rd.addr];
        end
    end

    assign rd_data.sonar_stamp = sonar_q_reg[HALF_BITS-1:TAG_BITS];
    assign rd_data.sonar_tag   = sonar_q_reg[TAG_BITS-1:0];
    assign rd_data.fix_stamp   = fix_q_reg[HALF_BITS-1:TAG_BITS];
    assign rd_data.fix_tag     = fix_q_reg[TAG_BITS-1:0];

endmodule

### src/sngb_front.sv
// front end: accepts items, decodes the command, queues decoded entries
// depends on sngb_pkg
`timescale 1ns / 1ps

module sngb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  sngb_pkg::item_t item,
    input  logic            item_valid,
    output logic            item_ready,
    output sngb_pkg::entry_t q_entry,
    output logic            q_valid,
    input  logic            q_ready
);
    import sngb_pkg::*;

    entry_t                    queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg, cnt_next;
    entry_t                    entry_dec;
    op_t                       op_dec;
    logic                      push, pop;

    // command decode, fields that the command does not use are cleared
    always_comb
    begin
        op_dec = '0;
        case (item.cmd)
            CMD_START: op_dec.is_start = 1'b1;
            CMD_SOS:   op_dec.is_sos   = 1'b1;
            CMD_FIX:   op_dec.is_fix   = 1'b1;
            CMD_SONAR: op_dec.is_sonar = 1'b1;
            default:   op_dec = '0;
        endcase
        entry_dec.op        = op_dec;
        entry_dec.stamp     = (op_dec.is_fix || op_dec.is_sonar) ? item.stamp : '0;
        entry_dec.tag       = (op_dec.is_fix || op_dec.is_sonar) ? item.tag : '0;
        entry_dec.sos_value = (op_dec.is_start || op_dec.is_sos) ? item.sos_value : '0;
    end

    // queue handshake
    assign item_ready = (cnt_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign q_valid    = (cnt_reg != '0);
    assign q_entry    = queue_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = q_valid && q_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QUEUE_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry_dec;
        end
    end

endmodule

### src/sngb_back.sv
// back end: batch state, slot store walk on a gnss fix, output register
// depends on sngb_pkg and sngb_slot_store
`timescale 1ns / 1ps

module sngb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sngb_pkg::entry_t q_entry,
    input  logic             q_valid,
    output logic             q_ready,
    output sngb_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_ready
);
    import sngb_pkg::*;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_WALK = 2'b10
    } fsm_t;

    fsm_t                     fsm_reg, fsm_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [COUNT_BITS-1:0]    pending_reg, pending_next;
    batch_state_t             state_reg, state_next;
    logic [STAMP_BITS-1:0]    prior_stamp_reg, prior_stamp_next;
    logic [TAG_BITS-1:0]      prior_tag_reg, prior_tag_next;
    logic [SOS_BITS-1:0]      sos_first_reg, sos_first_next;
    logic [SOS_BITS-1:0]      sos_second_reg, sos_second_next;
    logic [STAMP_BITS-1:0]    fresh_stamp_reg, fresh_stamp_next;
    logic [TAG_BITS-1:0]      fresh_tag_reg, fresh_tag_next;
    logic [SLOT_IDX_BITS-1:0] idx_reg, idx_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    slot_wr_t                 slot_wr;
    slot_rd_t                 slot_rd;
    slot_t                    slot_q;

    logic                     out_free, walk_item, take, at_end, fresh_nearer, dropped;
    logic [STAMP_BITS:0]      near_lhs, near_rhs;
    logic [SLOT_IDX_BITS-1:0] first_idx, prev_idx;

    sngb_slot_store u_store (
        .clk     (clk),
        .wr      (slot_wr),
        .rd      (slot_rd),
        .rd_data (slot_q)
    );

    // handshake toward the queue
    assign out_free  = !out_valid_reg || result_ready;
    assign walk_item = q_entry.op.is_fix && (state_reg != BS_COMPLETE)
                       && (count_reg > pending_reg);
    assign q_ready   = (fsm_reg == FSM_IDLE) && (walk_item || out_free);
    assign take      = q_valid && q_ready;

    // nearness: fresh - sonar < sonar - old, i.e. fresh + old < 2 * sonar
    assign near_lhs     = {1'b0, fresh_stamp_reg} + {1'b0, slot_q.fix_stamp};
    assign near_rhs     = {slot_q.sonar_stamp, 1'b0};
    assign fresh_nearer = (near_lhs < near_rhs);

    assign at_end    = (COUNT_BITS'(idx_reg) == pending_reg);
    assign first_idx = SLOT_IDX_BITS'(count_reg - COUNT_BITS'(1));
    assign prev_idx  = idx_reg - SLOT_IDX_BITS'(1);

    // command execution and slot walk
    always_comb
    begin
        fsm_next         = fsm_reg;
        count_next       = count_reg;
        pending_next     = pending_reg;
        state_next       = state_reg;
        prior_stamp_next = prior_stamp_reg;
        prior_tag_next   = prior_tag_reg;
        sos_first_next   = sos_first_reg;
        sos_second_next  = sos_second_reg;
        fresh_stamp_next = fresh_stamp_reg;
        fresh_tag_next   = fresh_tag_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg && !result_ready;
        out_next         = out_reg;
        slot_wr          = '0;
        slot_rd          = '0;
        dropped          = 1'b0;

        case (fsm_reg)
            FSM_IDLE:
            begin
                if (take && walk_item)
                begin
                    // latch the fix and read the newest pending slot
                    fresh_stamp_next = q_entry.stamp;
                    fresh_tag_next   = q_entry.tag;
                    idx_next         = first_idx;
                    slot_rd.en       = 1'b1;
                    slot_rd.addr     = first_idx;
                    fsm_next         = FSM_WALK;
                end
                else if (take)
                begin
                    if (q_entry.op.is_start)
                    begin
                        count_next       = '0;
                        pending_next     = '0;
                        state_next       = BS_SOS_MISSING;
                        prior_stamp_next = '0;
                        prior_tag_next   = '0;
                        sos_first_next   = q_entry.sos_value;
                        sos_second_next  = '0;
                    end
                    else if (q_entry.op.is_sos)
                    begin
                        if (state_reg == BS_SOS_MISSING)
                        begin
                            sos_second_next = q_entry.sos_value;
                            state_next = (count_reg > pending_reg) ? BS_GNSS_MISSING
                                         : BS_COMPLETE;
                        end
                    end
                    else if (q_entry.op.is_fix)
                    begin
                        // fix with nothing pending
                        if (state_reg == BS_GNSS_MISSING)
                        begin
                            state_next = BS_COMPLETE;
                        end
                        else if (state_reg == BS_SOS_MISSING)
                        begin
                            prior_stamp_next = q_entry.stamp;
                            prior_tag_next   = q_entry.tag;
                        end
                        pending_next = count_reg;
                    end
                    else if (q_entry.op.is_sonar)
                    begin
                        if (state_reg == BS_SOS_MISSING)
                        begin
                            if (count_reg < COUNT_BITS'(SLOT_COUNT))
                            begin
                                slot_wr.sonar_en         = 1'b1;
                                slot_wr.fix_en           = 1'b1;
                                slot_wr.addr             = SLOT_IDX_BITS'(count_reg);
                                slot_wr.data.sonar_stamp = q_entry.stamp;
                                slot_wr.data.sonar_tag   = q_entry.tag;
                                slot_wr.data.fix_stamp   = prior_stamp_reg;
                                slot_wr.data.fix_tag     = prior_tag_reg;
                                count_next = count_reg + COUNT_BITS'(1);
                            end
                            else
                            begin
                                dropped = 1'b1;
                            end
                        end
                    end

                    // status result
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.batch_state  = state_next;
                    out_next.slot_dropped = dropped;
                    out_next.sos_first    = sos_first_next;
                    out_next.sos_second   = sos_second_next;
                    out_next.last         = 1'b1;
                end
            end

            FSM_WALK:
            begin
                if (out_free)
                begin
                    // update the slot when the fresh fix is strictly nearer
                    slot_wr.fix_en         = fresh_nearer;
                    slot_wr.addr           = idx_reg;
                    slot_wr.data.fix_stamp = fresh_stamp_reg;
                    slot_wr.data.fix_tag   = fresh_tag_reg;

                    out_valid_next        = 1'b1;
                    out_next.batch_state  = (at_end && (state_reg == BS_GNSS_MISSING))
                                            ? BS_COMPLETE : state_reg;
                    out_next.slot_valid   = 1'b1;
                    out_next.slot_index   = INDEX_OUT_BITS'(idx_reg);
                    out_next.sonar_tag    = slot_q.sonar_tag;
                    out_next.fix_tag      = fresh_nearer ? fresh_tag_reg : slot_q.fix_tag;
                    out_next.fix_stamp    = fresh_nearer ? fresh_stamp_reg
                                            : slot_q.fix_stamp;
                    out_next.slot_dropped = 1'b0;
                    out_next.sos_first    = sos_first_reg;
                    out_next.sos_second   = sos_second_reg;
                    out_next.last         = at_end;

                    if (at_end)
                    begin
                        pending_next = count_reg;
                        if (state_reg == BS_GNSS_MISSING)
                        begin
                            state_next = BS_COMPLETE;
                        end
                        else if (state_reg == BS_SOS_MISSING)
                        begin
                            prior_stamp_next = fresh_stamp_reg;
                            prior_tag_next   = fresh_tag_reg;
                        end
                        fsm_next = FSM_IDLE;
                    end
                    else
                    begin
                        idx_next     = prev_idx;
                        slot_rd.en   = 1'b1;
                        slot_rd.addr = prev_idx;
                    end
                end
            end

            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    // control and batch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= FSM_IDLE;
            count_reg       <= '0;
            pending_reg     <= '0;
            state_reg       <= BS_SOS_MISSING;
            prior_stamp_reg <= '0;
            prior_tag_reg   <= '0;
            sos_first_reg   <= '0;
            sos_second_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fsm_reg         <= fsm_next;
            count_reg       <= count_next;
            pending_reg     <= pending_next;
            state_reg       <= state_next;
            prior_stamp_reg <= prior_stamp_next;
            prior_tag_reg   <= prior_tag_next;
            sos_first_reg   <= sos_first_next;
            sos_second_reg  <= sos_second_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fresh_stamp_reg <= fresh_stamp_next;
        fresh_tag_reg   <= fresh_tag_next;
        idx_reg         <= idx_next;
        out_reg         <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

### test/tb_sonar_gnss_nearest_fix_batcher_core.sv
// testbench for the sonar / gnss nearest-fix batcher top level
// drives directed and random command streams and checks every result against a local predictor
// depends on sngb_pkg and sonar_gnss_nearest_fix_batcher_core
`timescale 1ns / 1ps

module tb_sonar_gnss_nearest_fix_batcher_core;

    import sngb_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTED  = 10;
    localparam int RANDOM_ITEMS  = 90;

    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
    localparam logic [TAG_BITS-1:0]   TAG_MAX   = '1;
    localparam logic [SOS_BITS-1:0]   SOS_MAX   = '1;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    sonar_gnss_nearest_fix_batcher_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // batch state as the block should hold it
    logic [STAMP_BITS-1:0] ping_stamp [SLOT_COUNT];
    logic [TAG_BITS-1:0]   ping_tag [SLOT_COUNT];
    logic [STAMP_BITS-1:0] paired_stamp [SLOT_COUNT];
    logic [TAG_BITS-1:0]   paired_tag [SLOT_COUNT];
    int unsigned           used_slots     = 0;
    int unsigned           open_from      = 0;
    batch_state_t          bstate         = BS_SOS_MISSING;
    logic [STAMP_BITS-1:0] last_fix_stamp = '0;
    logic [TAG_BITS-1:0]   last_fix_tag   = '0;
    logic [SOS_BITS-1:0]   sos_a          = '0;
    logic [SOS_BITS-1:0]   sos_b          = '0;

    result_t     batch_reports[$];
    int unsigned effective_items = 0;
    int unsigned error_count     = 0;
    int unsigned burst_left      = 0;

    // exact nearness test: fresh - ping < ping - old, done as fresh + old < 2 * ping
    function automatic bit fix_is_nearer(input logic [STAMP_BITS-1:0] ping,
                                         input logic [STAMP_BITS-1:0] old_fix,
                                         input logic [STAMP_BITS-1:0] fresh);
        logic [STAMP_BITS+1:0] lhs;
        logic [STAMP_BITS+1:0] rhs;
        lhs = {2'b00, fresh} + {2'b00, old_fix};
        rhs = {1'b0, ping, 1'b0};
        return lhs < rhs;
    endfunction

    function automatic result_t make_report(input logic                      valid,
                                            input logic [INDEX_OUT_BITS-1:0] idx,
                                            input logic [TAG_BITS-1:0]       stag,
                                            input logic [TAG_BITS-1:0]       ftag,
                                            input logic [STAMP_BITS-1:0]     fstamp,
                                            input logic                      dropped,
                                            input logic                      fin);
        result_t r;
        r.batch_state  = bstate;
        r.slot_valid   = valid;
        r.slot_index   = idx;
        r.sonar_tag    = stag;
        r.fix_tag      = ftag;
        r.fix_stamp    = fstamp;
        r.slot_dropped = dropped;
        r.sos_first    = sos_a;
        r.sos_second   = sos_b;
        r.last         = fin;
        return r;
    endfunction

    // append one awaited result at the tail of the list
    function automatic void queue_report(input result_t r);
        batch_reports.insert(batch_reports.size(), r);
    endfunction

    // apply one accepted command and queue the results it causes
    // returns 1 unless the block ignores the command
    function automatic bit advance_batch(input item_t it);
        int unsigned i;
        int unsigned walked;
        bit          effect;
        logic        dropped;
        effect  = 1'b1;
        dropped = 1'b0;
        walked  = 0;
        case (it.cmd)
            CMD_START:
            begin
                used_slots     = 0;
                open_from      = 0;
                bstate         = BS_SOS_MISSING;
                last_fix_stamp = '0;
                last_fix_tag   = '0;
                sos_a          = it.sos_value;
                sos_b          = '0;
            end
            CMD_SOS:
            begin
                if (bstate == BS_SOS_MISSING)
                begin
                    sos_b  = it.sos_value;
                    bstate = (used_slots > open_from) ? BS_GNSS_MISSING : BS_COMPLETE;
                end
                else
                    effect = 1'b0;
            end
            CMD_FIX:
            begin
                if (bstate != BS_COMPLETE)
                begin
                    // pending slots newest first, ties keep the earlier fix
                    i = used_slots;
                    while (i > open_from)
                    begin
                        i--;
                        if (fix_is_nearer(ping_stamp[i], paired_stamp[i], it.stamp))
                        begin
                            paired_stamp[i] = it.stamp;
                            paired_tag[i]   = it.tag;
                        end
                        if (i == open_from && bstate == BS_GNSS_MISSING)
                            bstate = BS_COMPLETE;
                        queue_report(make_report(1'b1, INDEX_OUT_BITS'(i),
                            ping_tag[i], paired_tag[i], paired_stamp[i], 1'b0,
                            i == open_from));
                        walked++;
                    end
                    open_from = used_slots;
                    if (bstate == BS_GNSS_MISSING)
                        bstate = BS_COMPLETE;
                    else if (bstate == BS_SOS_MISSING)
                    begin
                        last_fix_stamp = it.stamp;
                        last_fix_tag   = it.tag;
                    end
                end
                else
                    effect = 1'b0;
            end
            default:
            begin
                if (bstate == BS_SOS_MISSING)
                begin
                    if (used_slots < SLOT_COUNT)
                    begin
                        ping_stamp[used_slots]   = it.stamp;
                        ping_tag[used_slots]     = it.tag;
                        paired_stamp[used_slots] = last_fix_stamp;
                        paired_tag[used_slots]   = last_fix_tag;
                        used_slots++;
                    end
                    else
                        dropped = 1'b1;
                end
                else
                    effect = 1'b0;
            end
        endcase
        // status result for anything that completed no slot
        if (walked == 0)
            queue_report(make_report(1'b0, '0, '0, '0, '0, dropped, 1'b1));
        return effect;
    endfunction

    function automatic string show_report(input result_t r);
        return $sformatf("st=%0d v=%0d idx=%0d stag=%h ftag=%h fstamp=%h drop=%0d sos1=%h sos2=%h last=%0d",
            r.batch_state, r.slot_valid, r.slot_index, r.sonar_tag, r.fix_tag, r.fix_stamp,
            r.slot_dropped, r.sos_first, r.sos_second, r.last);
    endfunction

    function automatic string differing_fields(input result_t got, input result_t want);
        string s;
        s = "";
        if (got.batch_state !== want.batch_state)   s = {s, " batch_state"};
        if (got.slot_valid !== want.slot_valid)     s = {s, " slot_valid"};
        if (got.slot_index !== want.slot_index)     s = {s, " slot_index"};
        if (got.sonar_tag !== want.sonar_tag)       s = {s, " sonar_tag"};
        if (got.fix_tag !== want.fix_tag)           s = {s, " fix_tag"};
        if (got.fix_stamp !== want.fix_stamp)       s = {s, " fix_stamp"};
        if (got.slot_dropped !== want.slot_dropped) s = {s, " slot_dropped"};
        if (got.sos_first !== want.sos_first)       s = {s, " sos_first"};
        if (got.sos_second !== want.sos_second)     s = {s, " sos_second"};
        if (got.last !== want.last)                 s = {s, " last"};
        return s;
    endfunction

    // result checker; values are settled at the falling edge before the transfer edge
    always @(negedge clk)
    begin : check_result
        result_t want;
        string   bad;
        if (rst_n && result_valid && result_ready)
        begin
            if (batch_reports.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTED)
                    $display("%0t: result with none awaited: %s", $time, show_report(result));
            end
            else
            begin
                want = batch_reports.pop_front();
                bad  = differing_fields(result, want);
                if (bad != "")
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTED)
                        $display("%0t: mismatch in%s\n  want %s\n  got  %s", $time, bad,
                                 show_report(want), show_report(result));
                end
            end
        end
    end

    // receiver stalls: always ready, coin flips, stall bursts, rare stalls
    logic [9:0]  ready_phase = '0;
    int unsigned stall_left  = 0;

    always @(posedge clk)
    begin
        ready_phase <= ready_phase + 1'b1;
        case (ready_phase[9:8])
            2'd0: result_ready <= 1'b1;
            2'd1: result_ready <= ($urandom_range(0, 1) == 1);
            2'd2:
            begin
                if (stall_left != 0)
                begin
                    stall_left   <= stall_left - 1;
                    result_ready <= 1'b0;
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    stall_left   <= $urandom_range(1, 8);
                    result_ready <= 1'b0;
                end
                else
                    result_ready <= 1'b1;
            end
            default: result_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // one transfer on the item channel, then the sender's burst and gap pacing
    task automatic send_item(input item_t it);
        item       <= it;
        item_valid <= 1'b1;
        do
            @(negedge clk);
        while (!item_ready);
        @(posedge clk);
        if (advance_batch(it))
            effective_items++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_cmd(input logic [CMD_BITS-1:0]   c,
                            input logic [STAMP_BITS-1:0] st,
                            input logic [TAG_BITS-1:0]   tg,
                            input logic [SOS_BITS-1:0]   sv);
        item_t it;
        it.cmd       = c;
        it.stamp     = st;
        it.tag       = tg;
        it.sos_value = sv;
        send_item(it);
    endtask

    // hold the sender until every awaited result has come out
    task automatic wait_all_reports();
        item_valid <= 1'b0;
        while (batch_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [STAMP_BITS-1:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[STAMP_BITS-1:0];
    endfunction

    function automatic logic [TAG_BITS-1:0] rand_tag();
        return TAG_BITS'($urandom());
    endfunction

    // stamp extremes, commands before any start, late and ignored commands
    task automatic test_stamp_extremes();
        send_cmd(CMD_FIX, STAMP_MAX, TAG_MAX, 32'h0000_0000);
        send_cmd(CMD_SONAR, '0, '0, SOS_MAX);
        send_cmd(CMD_SONAR, STAMP_MAX, TAG_MAX, 32'h0000_0000);
        send_cmd(CMD_SOS, 48'h0, 16'h0, SOS_MAX);
        send_cmd(CMD_SONAR, 48'h5555_5555_5555, 16'h5555, 32'h5555_5555);
        send_cmd(CMD_SOS, 48'hAAAA_AAAA_AAAA, 16'hAAAA, 32'h0000_0000);
        send_cmd(CMD_FIX, '0, '0, 32'hAAAA_AAAA);
        send_cmd(CMD_FIX, 48'h1234_5678_9ABC, 16'h1234, 32'h0);
    endtask

    // nearer fix wins, ties keep the earlier fix, out-of-order fix stamps
    task automatic test_nearness();
        send_cmd(CMD_START, '0, '0, 32'h0000_0000);
        send_cmd(CMD_FIX, 48'd100, 16'h00A1, '0);
        send_cmd(CMD_SONAR, 48'd150, 16'h0B01, '0);
        send_cmd(CMD_SONAR, 48'd160, 16'h0B02, '0);
        send_cmd(CMD_SONAR, 48'd180, 16'h0B03, '0);
        send_cmd(CMD_FIX, 48'd200, 16'h00A2, '0);
        send_cmd(CMD_SONAR, 48'd250, 16'h0B04, '0);
        send_cmd(CMD_FIX, 48'd299, 16'h00A3, '0);
        send_cmd(CMD_FIX, 48'd100, 16'h00A4, '0);
        send_cmd(CMD_SOS, '0, '0, 32'h0000_05DC);
        send_cmd(CMD_SONAR, 48'd300, 16'h0B05, '0);
    endtask

    // start in the middle of a batch drops its pending slots
    task automatic test_restart();
        send_cmd(CMD_START, '0, '0, 32'hAAAA_AAAA);
        send_cmd(CMD_SONAR, 48'd10, 16'h0C01, '0);
        send_cmd(CMD_SONAR, 48'd20, 16'h0C02, '0);
        send_cmd(CMD_START, '0, '0, 32'h5555_5555);
        send_cmd(CMD_SOS, '0, '0, 32'h0000_1234);
        send_cmd(CMD_START, '0, '0, SOS_MAX);
        send_cmd(CMD_SONAR, 48'd1000, 16'h0D01, '0);
        send_cmd(CMD_FIX, 48'd900, 16'h0E01, '0);
        send_cmd(CMD_SONAR, 48'd1100, 16'h0D02, '0);
        send_cmd(CMD_SOS, '0, '0, 32'h0000_5DC0);
        send_cmd(CMD_FIX, 48'd1150, 16'h0E02, '0);
    endtask

    // fill the store, drop the overflow, then one fix walks every slot
    task automatic test_store_full();
        send_cmd(CMD_START, rand_stamp(), rand_tag(), $urandom());
        send_cmd(CMD_FIX, 48'd500, 16'h0F00, '0);
        for (int k = 0; k < SLOT_COUNT + 2; k++)
            send_cmd(CMD_SONAR, STAMP_BITS'(1000 * k), TAG_BITS'(k), $urandom());
        send_cmd(CMD_SOS, rand_stamp(), rand_tag(), $urandom());
        send_cmd(CMD_FIX, 48'd20000, 16'h0F01, '0);
    endtask

    task automatic send_noise();
        send_cmd(CMD_BITS'($urandom_range(0, 3)), rand_stamp(), rand_tag(), $urandom());
    endtask

    // one well-formed batch with random content and a little noise
    task automatic run_batch();
        logic [STAMP_BITS-1:0] base;
        int unsigned           spread;
        int unsigned           n_ping;
        base   = ($urandom_range(0, 3) == 0) ? STAMP_MAX - STAMP_BITS'($urandom_range(0, 3000))
                                             : rand_stamp();
        spread = ($urandom_range(0, 1) == 1) ? 20 : 5000;
        n_ping = ($urandom_range(0, 9) == 0) ? $urandom_range(SLOT_COUNT - 2, SLOT_COUNT + 4)
                                             : $urandom_range(0, 8);
        send_cmd(CMD_START, rand_stamp(), rand_tag(), $urandom());
        if ($urandom_range(0, 1) == 1)
            send_cmd(CMD_FIX, base + STAMP_BITS'($urandom_range(0, spread)), rand_tag(), $urandom());
        for (int k = 0; k < n_ping; k++)
        begin
            send_cmd(CMD_SONAR, base + STAMP_BITS'(k * spread / 2 + $urandom_range(0, spread)),
                     rand_tag(), $urandom());
            if ($urandom_range(0, 9) < 3)
                send_cmd(CMD_FIX, base + STAMP_BITS'(k * spread / 2 + $urandom_range(0, spread)),
                         rand_tag(), $urandom());
            if ($urandom_range(0, 19) == 0)
                send_noise();
        end
        if ($urandom_range(0, 4) == 0)
            send_cmd(CMD_FIX, base + STAMP_BITS'(n_ping * spread / 2), rand_tag(), $urandom());
        send_cmd(CMD_SOS, rand_stamp(), rand_tag(), $urandom());
        if ($urandom_range(0, 9) < 3)
            send_cmd(CMD_SONAR, base + STAMP_BITS'($urandom_range(0, spread)), rand_tag(), $urandom());
        send_cmd(CMD_FIX, base + STAMP_BITS'(n_ping * spread / 2 + $urandom_range(0, spread)),
                 rand_tag(), $urandom());
        if ($urandom_range(0, 4) == 0)
            send_cmd(CMD_FIX, rand_stamp(), rand_tag(), $urandom());
    endtask

    task automatic test_random_batches();
        int unsigned goal;
        goal = effective_items + RANDOM_ITEMS;
        while (effective_items < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                run_batch();
            if ($urandom_range(0, 7) == 0)
                wait_all_reports();
        end
    endtask

    // test sequence
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stamp_extremes();
        wait_all_reports();
        test_nearness();
        wait_all_reports();
        test_restart();
        wait_all_reports();
        test_store_full();
        wait_all_reports();
        test_random_batches();
        wait_all_reports();
        if (error_count == 0 && batch_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/sngb_pkg.sv
src/sngb_slot_store.sv
src/sngb_front.sv
src/sngb_back.sv
src/sonar_gnss_nearest_fix_batcher_core.sv
test/tb_sonar_gnss_nearest_fix_batcher_core.sv
